// ===== rtl/core/chm_pkg.sv =====
// Shared types, constants and codes of the chained hash map engine.
`default_nettype none
package chm_pkg;

  // Pool and bucket sizing
  localparam int MAX_ENTRIES = 64;
  localparam int NUM_BUCKETS = 64;
  localparam int SLOT_W      = $clog2(MAX_ENTRIES);
  localparam int LINK_W      = $clog2(MAX_ENTRIES + 1);
  localparam int BKT_W       = $clog2(NUM_BUCKETS);
  localparam int CAP_W       = 7;
  localparam int CNT_W       = 7;
  localparam int CAP_LIM     = (NUM_BUCKETS < MAX_ENTRIES) ? NUM_BUCKETS : MAX_ENTRIES;

  // Hash mixing
  localparam logic [31:0] HASH_MUL     = 32'h7feb352d;
  localparam int          HASH_SHIFT_A = 16;
  localparam int          HASH_SHIFT_B = 15;

  // Remainder unit: bits taken per cycle
  localparam int DIV_STEP  = 4;
  localparam int DIV_ITERS = 32 / DIV_STEP;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  // Commands
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_RM_FAIL   = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] key;
    logic [1:0]         new_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [1:0] found_value;
    logic [6:0] entry_total;
    logic       table_full;
  } out_item_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic [1:0]       command;
    logic [31:0]      key;
    logic [1:0]       new_value;
    logic [BKT_W-1:0] bucket;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/core/chm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/chm_front.sv =====
// Front end: accepts items, hashes the key and reduces it modulo the capacity.
`default_nettype none
module chm_front import chm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CAP_W-1:0] cap_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_item_t         in_item_i,
  output logic                  job_valid_o,
  input  wire logic             job_full_i,
  output job_t                  job_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]           state_q, state_d;
  in_item_t             item_q, item_d;
  logic [31:0]          div_q, div_d;
  logic [CAP_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]          mix_a, prod, mix_b;
  logic [CAP_W-1:0]     rem_step;

  // Hash: xor-shift, multiply, xor-shift
  always_comb begin
    mix_a = 32'(item_q.key) ^ (32'(item_q.key) >> HASH_SHIFT_A);
    prod  = 32'(mix_a * HASH_MUL);
    mix_b = prod ^ (prod >> HASH_SHIFT_B);
  end

  // Restoring remainder, a few dividend bits per cycle
  always_comb begin
    rem_step = rem_q;
    for (int i = 0; i < DIV_STEP; i++) begin
      rem_step = {rem_step[CAP_W-2:0], div_q[31-i]};
      if (rem_step >= cap_i) begin
        rem_step = rem_step - cap_i;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    div_d   = div_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        div_d   = mix_b;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = F_DIV;
      end
      F_DIV: begin
        rem_d = rem_step;
        div_d = div_q << DIV_STEP;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_ITERS - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!job_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
  end

  assign in_stall_o        = (state_q != F_IDLE);
  assign job_valid_o       = (state_q == F_PUSH);
  assign job_o.command     = item_q.command;
  assign job_o.key         = 32'(item_q.key);
  assign job_o.new_value   = item_q.new_value;
  assign job_o.bucket      = rem_q[BKT_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/chm_fifo.sv =====
// Two-entry item queue between the front and back ends.
`default_nettype none
module chm_fifo import chm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      pop_data_o
);

  job_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] fill_q;

  assign full_o     = (fill_q == 2'd2);
  assign valid_o    = (fill_q != 2'd0);
  assign pop_data_o = mem_q[rptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/chm_back.sv =====
// Back end: walks the bucket chain, updates the map and holds the result item.
`default_nettype none
module chm_back import chm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CAP_W-1:0] cap_i,
  input  wire logic             job_valid_i,
  input  wire job_t             job_i,
  output logic                  job_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_item_t             out_item_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HEAD = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0]       state_q, state_d;
  job_t             job_q;
  logic [LINK_W-1:0] head_link_q, cur_q, prev_q, hit_q, hit_next_q;
  logic [LINK_W-1:0] head_link_d, cur_d, prev_d, hit_d, hit_next_d;
  logic [1:0]       hit_val_q, hit_val_d;
  logic [LINK_W-1:0] steps_q, steps_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [LINK_W-1:0] sp_q, sp_d, fresh_q, fresh_d;
  logic [NUM_BUCKETS-1:0] head_vld_q;
  logic             out_valid_q;
  out_item_t        out_q;

  // RAM ports
  logic [LINK_W-1:0] head_rdata, next_rdata, head_wdata, next_wdata;
  logic              head_we, key_we, val_we, next_we, stk_we;
  logic [SLOT_W-1:0] walk_addr, val_waddr, next_waddr, stk_rdata, new_slot;
  logic [31:0]       key_rdata;
  logic [1:0]        val_rdata;

  logic out_free, is_full, key_match, steps_end;
  logic [LINK_W-1:0] head_link, nxt;
  out_item_t res;

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_full  = (count_q >= cap_i);
  assign head_link = head_vld_q[job_q.bucket] ? head_rdata : '0;
  assign key_match = (key_rdata == job_q.key);
  assign nxt       = next_rdata;
  assign steps_end = (steps_q + 1'b1) >= LINK_W'(MAX_ENTRIES);
  assign new_slot  = (sp_q != '0) ? stk_rdata : fresh_q[SLOT_W-1:0];

  // Walk read address follows the link just fetched
  always_comb begin
    if (state_q == S_HEAD) begin
      walk_addr = SLOT_W'(head_link - 1'b1);
    end else begin
      walk_addr = SLOT_W'(nxt - 1'b1);
    end
  end

  // Control and update
  always_comb begin
    state_d     = state_q;
    head_link_d = head_link_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    hit_d       = hit_q;
    hit_next_d  = hit_next_q;
    hit_val_d   = hit_val_q;
    steps_d     = steps_q;
    count_d     = count_q;
    sp_d        = sp_q;
    fresh_d     = fresh_q;
    job_pop_o   = 1'b0;
    head_we     = 1'b0;
    head_wdata  = '0;
    key_we      = 1'b0;
    val_we      = 1'b0;
    val_waddr   = '0;
    next_we     = 1'b0;
    next_waddr  = '0;
    next_wdata  = '0;
    stk_we      = 1'b0;
    res         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          hit_d     = '0;
          hit_val_d = '0;
          state_d   = (job_i.command == CMD_INSERT || job_i.command == CMD_GET ||
                       job_i.command == CMD_REMOVE) ? S_HEAD : S_EXEC;
        end
      end
      S_HEAD: begin
        head_link_d = head_link;
        prev_d      = '0;
        steps_d     = '0;
        cur_d       = head_link;
        if (head_link == '0 || head_link > LINK_W'(MAX_ENTRIES)) begin
          state_d = S_EXEC;
        end else begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (key_match) begin
          hit_d      = cur_q;
          hit_next_d = nxt;
          hit_val_d  = val_rdata;
          state_d    = S_EXEC;
        end else if (nxt == '0 || nxt > LINK_W'(MAX_ENTRIES) || steps_end) begin
          state_d = S_EXEC;
        end else begin
          prev_d  = cur_q;
          cur_d   = nxt;
          steps_d = steps_q + 1'b1;
        end
      end
      S_EXEC: begin
        res.found = (hit_q != '0);
        case (job_q.command)
          CMD_INSERT: begin
            if (is_full) begin
              res.status = ST_FULL;
            end else if (hit_q != '0) begin
              val_we    = out_free;
              val_waddr = SLOT_W'(hit_q - 1'b1);
            end else begin
              key_we     = out_free;
              val_we     = out_free;
              val_waddr  = new_slot;
              next_we    = out_free;
              next_waddr = new_slot;
              next_wdata = head_link_q;
              head_we    = out_free;
              head_wdata = LINK_W'(new_slot) + 1'b1;
              count_d    = count_q + 1'b1;
              if (sp_q != '0) sp_d = sp_q - 1'b1;
              else            fresh_d = fresh_q + 1'b1;
            end
          end
          CMD_GET: begin
            if (hit_q != '0) res.found_value = hit_val_q;
            else             res.status      = ST_NOT_FOUND;
          end
          CMD_REMOVE: begin
            if (hit_q != '0) begin
              if (prev_q != '0) begin
                next_we    = out_free;
                next_waddr = SLOT_W'(prev_q - 1'b1);
                next_wdata = hit_next_q;
              end else begin
                head_we    = out_free;
                head_wdata = hit_next_q;
              end
              stk_we  = out_free;
              sp_d    = sp_q + 1'b1;
              count_d = count_q - 1'b1;
            end else begin
              res.status = ST_RM_FAIL;
            end
          end
          default: res.found = 1'b0;
        endcase
        res.entry_total = count_d;
        res.table_full  = (count_d >= cap_i);
        if (out_free) begin
          state_d = S_IDLE;
        end else begin
          count_d = count_q;
          sp_d    = sp_q;
          fresh_d = fresh_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      sp_q        <= '0;
      fresh_q     <= '0;
      head_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sp_q    <= sp_d;
      fresh_q <= fresh_d;
      if (head_we) head_vld_q[job_q.bucket] <= 1'b1;
      if (state_q == S_EXEC && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)             out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (job_pop_o) job_q <= job_i;
    head_link_q <= head_link_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    hit_q       <= hit_d;
    hit_next_q  <= hit_next_d;
    hit_val_q   <= hit_val_d;
    steps_q     <= steps_d;
    if (state_q == S_EXEC && out_free) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Bucket heads
  chm_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BUCKETS)) u_head_ram (
    .clk_i, .we_i(head_we), .waddr_i(job_q.bucket), .wdata_i(head_wdata),
    .raddr_i(job_i.bucket), .rdata_o(head_rdata)
  );

  // Entry slots
  chm_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(new_slot), .wdata_i(job_q.key),
    .raddr_i(walk_addr), .rdata_o(key_rdata)
  );

  chm_ram #(.WIDTH(2), .DEPTH(MAX_ENTRIES)) u_val_ram (
    .clk_i, .we_i(val_we), .waddr_i(val_waddr), .wdata_i(job_q.new_value),
    .raddr_i(walk_addr), .rdata_o(val_rdata)
  );

  chm_ram #(.WIDTH(LINK_W), .DEPTH(MAX_ENTRIES)) u_next_ram (
    .clk_i, .we_i(next_we), .waddr_i(next_waddr), .wdata_i(next_wdata),
    .raddr_i(walk_addr), .rdata_o(next_rdata)
  );

  // Stack of freed slots
  chm_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ENTRIES)) u_stk_ram (
    .clk_i, .we_i(stk_we), .waddr_i(sp_q[SLOT_W-1:0]),
    .wdata_i(SLOT_W'(hit_q - 1'b1)),
    .raddr_i(SLOT_W'(sp_q - 1'b1)), .rdata_o(stk_rdata)
  );

endmodule
`default_nettype wire

// ===== rtl/core/chained_hash_map_engine_core.sv =====
// Top level of the chained hash map engine.
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one command item: insert,
//   get or remove of a 32-bit key. Output channel (out_valid_o / out_stall_i)
//   returns one result item per command: status, found flag, stored value,
//   entry count and full flag. cfg_we_i writes the bucket capacity; write it
//   only while no item is in flight.
//   Steps: the front end accepts the item, hashes the key, reduces it in
//   the 4-bit-per-cycle remainder unit and hands it over; the back end
//   fetches the bucket head, visits the chain links one by one and then
//   updates the map. Front and back overlap through a two-entry queue;
//   the front end takes no new item until it has handed over the last
//   one, its remainder unit sets the pace, and long chains make the back
//   end the limit.
//   Reset empties the map and sets the capacity to 64; no clearing pass.
//   A stalled result stays in the output register; the back end then holds
//   its next result and the queue and front end fill and stall in turn.
`default_nettype none
module chained_hash_map_engine_core import chm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_item_t         in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_item_t             out_item_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i
);

  logic [CAP_W-1:0] cap_q, cap_eff;
  logic             job_valid, job_full, q_valid, q_pop;
  job_t             job, q_job;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(64);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Clamp to the usable range
  always_comb begin
    if (cap_q == '0)                      cap_eff = CAP_W'(1);
    else if (cap_q > CAP_W'(CAP_LIM))     cap_eff = CAP_W'(CAP_LIM);
    else                                  cap_eff = cap_q;
  end

  chm_front u_front (
    .clk_i, .rst_ni, .cap_i(cap_eff),
    .in_valid_i, .in_stall_o, .in_item_i,
    .job_valid_o(job_valid), .job_full_i(job_full), .job_o(job)
  );

  chm_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(job_valid && !job_full), .push_data_i(job), .full_o(job_full),
    .pop_i(q_pop), .valid_o(q_valid), .pop_data_o(q_job)
  );

  chm_back u_back (
    .clk_i, .rst_ni, .cap_i(cap_eff),
    .job_valid_i(q_valid), .job_i(q_job), .job_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .out_item_o
  );

`ifndef SYNTHESIS
  // Count never exceeds the pool
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.entry_total <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond pool size");

  // A refused insert always reports a full table
  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_FULL) |-> out_item_o.table_full)
    else $error("full status without full flag");

  // Only a successful lookup carries a value
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status != ST_OK) |-> out_item_o.found_value == 2'd0)
    else $error("value reported on failed item");

  // Queue never popped when empty
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire
